// ===== sv/mfb_pkg.sv =====
// Shared types and constants for the monochrome frame store blit engine.
// Depends on nothing; the frame memory, cursor, top level and testbench import it.
package mfb_pkg;

   localparam int SCREEN_WIDTH_DEF   = 792;
   localparam int SCREEN_HEIGHT_DEF  = 272;
   localparam int HALF_ROW_BYTES_DEF = 50;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_X_START    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_Y_START    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_WIDTH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_HEIGHT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PAD         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_ORDER_BIG  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_THRESHOLD = 3'd6;

   localparam logic [9:0] RECT_WIDTH_RESET      = 10'd792;
   localparam logic [8:0] RECT_HEIGHT_RESET     = 9'd272;
   localparam logic [9:0] LIGHT_THRESHOLD_RESET = 10'd382;
   localparam logic [7:0] WHITE_BYTE            = 8'hFF;

   typedef enum logic [1:0] {
      KIND_BLIT    = 2'd0,
      KIND_PLOT    = 2'd1,
      KIND_READ    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef struct packed {
      logic [9:0] rect_width;
      logic [8:0] rect_height;
      logic [9:0] row_pad;
   } cursor_cfg_type;

   typedef struct packed {
      logic step;
      logic restart;
   } cursor_ctrl_type;

   typedef struct packed {
      logic [9:0] column;
      logic [8:0] row;
      logic [9:0] pad_left;
   } cursor_state_type;

endpackage

// ===== sv/mfb_req_if.sv =====
// Request channel: valid/ready handshake carrying one blit, plot, read or restart word.
// Stands alone; used by the top level and the testbench.
interface mfb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] pixel_bytes;
   logic signed [10:0] plot_x;
   logic signed [9:0]  plot_y;
   logic        ink;
   logic        half;
   logic [8:0]  read_row;
   logic [5:0]  read_column;

   modport source (output valid, kind, pixel_bytes, plot_x, plot_y, ink, half,
                   read_row, read_column, input ready);
   modport sink (input valid, kind, pixel_bytes, plot_x, plot_y, ink, half,
                 read_row, read_column, output ready);
endinterface

// ===== sv/mfb_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one scan-out frame byte.
// Stands alone; used by the top level.
interface mfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;

   modport source (output valid, read_byte, input ready);
   modport sink (input valid, read_byte, output ready);
endinterface

// ===== sv/mfb_frame_mem.sv =====
// Frame store memory: one write port, one registered read port, and a clearing
// sweep after reset that fills every byte with white. Depends on mfb_pkg.
module mfb_frame_mem #(
   parameter int DEPTH = 26928,
   parameter int AW    = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   output logic          clear_busy
);
   import mfb_pkg::*;

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [7:0]    rd_data_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   assign mem_we    = clr_busy_ff | wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? WHITE_BYTE : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;
endmodule

// ===== sv/mfb_cursor.sv =====
// Blit cursor: walks the rectangle column by column, row by row, and counts
// the padding words skipped after each row. Depends on mfb_pkg.
module mfb_cursor (
   input  logic                     clock,
   input  logic                     reset,
   input  mfb_pkg::cursor_cfg_type   cfg,
   input  mfb_pkg::cursor_ctrl_type  ctrl,
   output mfb_pkg::cursor_state_type state
);
   import mfb_pkg::*;

   cursor_state_type cur_ff, cur_in;
   logic [9:0] width_eff;
   logic [8:0] height_eff;
   logic [9:0] col_next;
   logic [8:0] row_next;

   // A zero size behaves as one.
   assign width_eff  = (cfg.rect_width == '0) ? 10'd1 : cfg.rect_width;
   assign height_eff = (cfg.rect_height == '0) ? 9'd1 : cfg.rect_height;
   assign col_next   = cur_ff.column + 1'b1;
   assign row_next   = cur_ff.row + 1'b1;

   always_comb begin
      cur_in = cur_ff;
      if (ctrl.restart) begin
         cur_in = '0;
      end else if (ctrl.step) begin
         if (cur_ff.pad_left != '0) begin
            cur_in.pad_left = cur_ff.pad_left - 1'b1;
         end else if (col_next >= width_eff || col_next == '0) begin
            cur_in.column   = '0;
            cur_in.row      = row_next;
            cur_in.pad_left = cfg.row_pad;
            if (row_next >= height_eff || row_next == '0) begin
               cur_in.row      = '0;
               cur_in.pad_left = '0;
            end
         end else begin
            cur_in.column = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   assign state = cur_ff;
endmodule

// ===== sv/mono_framebuffer_blit_engine_top.sv =====
// Monochrome frame store with RGB565 threshold blitter, plot and scan-out read.
// Each word is accepted from idle, then passes the calculate, read and modify steps of the
// sequencer around the frame memory before the next is taken; the modify step of a read
// waits while an earlier response is still held. Skipped or off-screen words and restarts
// return to idle from the calculate step. After reset the memory clearing pass writes one
// frame byte per cycle (26928 at the default size) before req is ready.
module mono_framebuffer_blit_engine_top #(
   parameter int SCREEN_WIDTH   = mfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT  = mfb_pkg::SCREEN_HEIGHT_DEF,
   parameter int HALF_ROW_BYTES = mfb_pkg::HALF_ROW_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [mfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]  csr_write_data,
   mfb_req_if.sink                         req_chan,
   mfb_rsp_if.source                       rsp_chan
);
   import mfb_pkg::*;

   localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
   localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
   localparam int AW          = $clog2(FRAME_BYTES);
   localparam int START_BYTE  = (ROW_BYTES > HALF_ROW_BYTES) ?
                                (ROW_BYTES - HALF_ROW_BYTES) : 0;
   localparam int MW          = 12;
   localparam int LW          = 23;

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_READ, ST_MODIFY} state_type;

   // Configuration registers.
   logic signed [10:0] rect_x_ff;
   logic signed [9:0]  rect_y_ff;
   logic [9:0] rect_width_ff;
   logic [8:0] rect_height_ff;
   logic [9:0] row_pad_ff;
   logic       byte_order_big_ff;
   logic [9:0] light_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff          <= '0;
         rect_y_ff          <= '0;
         rect_width_ff      <= RECT_WIDTH_RESET;
         rect_height_ff     <= RECT_HEIGHT_RESET;
         row_pad_ff         <= '0;
         byte_order_big_ff  <= 1'b0;
         light_threshold_ff <= LIGHT_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RECT_X_START:    rect_x_ff          <= csr_write_data[10:0];
            CSR_RECT_Y_START:    rect_y_ff          <= csr_write_data[9:0];
            CSR_RECT_WIDTH:      rect_width_ff      <= csr_write_data[9:0];
            CSR_RECT_HEIGHT:     rect_height_ff     <= csr_write_data[8:0];
            CSR_ROW_PAD:         row_pad_ff         <= csr_write_data[9:0];
            CSR_BYTE_ORDER_BIG:  byte_order_big_ff  <= csr_write_data[0];
            CSR_LIGHT_THRESHOLD: light_threshold_ff <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // Sequencer, item holding registers and the response register.
   state_type   state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [15:0] pixel_ff;
   logic signed [10:0] plot_x_ff;
   logic signed [9:0]  plot_y_ff;
   logic        ink_ff, half_ff;
   logic [8:0]  read_row_ff;
   logic [5:0]  read_col_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]  bit_ff, bit_in;
   logic        white_ff, white_in;
   logic        rd_ok_ff, rd_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;

   cursor_cfg_type   cur_cfg;
   cursor_ctrl_type  cur_ctrl;
   cursor_state_type cur_state;

   logic        mem_wr_en, mem_rd_en, clear_busy;
   logic [7:0]  mem_wr_data, mem_rd_data, bit_mask;
   logic        req_accept, rsp_free;

   logic signed [11:0] pix_x;
   logic signed [10:0] pix_y;
   logic        is_read, on_screen;
   logic [15:0] pix565;
   logic [9:0]  colour_sum;
   logic [9:0]  mul_a;
   logic [MW-1:0] mul_b;
   logic [21:0] product;
   logic [10:0] add_term;
   logic [10:0] start_col;
   logic [LW-1:0] lin;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign is_read    = (kind_ff == KIND_READ);

   assign cur_cfg.rect_width  = rect_width_ff;
   assign cur_cfg.rect_height = rect_height_ff;
   assign cur_cfg.row_pad     = row_pad_ff;
   assign cur_ctrl.step    = (state_ff == ST_CALC) && (kind_ff == KIND_BLIT);
   assign cur_ctrl.restart = (state_ff == ST_CALC) && (kind_ff == KIND_RESTART);

   // Pixel coordinates and colour decision.
   always_comb begin
      if (kind_ff == KIND_BLIT) begin
         pix_x = $signed({rect_x_ff[10], rect_x_ff}) + $signed({2'b00, cur_state.column});
         pix_y = $signed({rect_y_ff[9], rect_y_ff}) + $signed({2'b00, cur_state.row});
      end else begin
         pix_x = $signed({plot_x_ff[10], plot_x_ff});
         pix_y = $signed({plot_y_ff[9], plot_y_ff});
      end
   end

   assign pix565     = byte_order_big_ff ? pixel_ff : {pixel_ff[7:0], pixel_ff[15:8]};
   assign colour_sum = 10'({pix565[15:11], 3'b000}) + 10'({pix565[10:5], 2'b00})
                     + 10'({pix565[4:0], 3'b000});
   assign on_screen  = !pix_x[11] && (32'(pix_x[10:0]) < SCREEN_WIDTH) &&
                       !pix_y[10] && (32'(pix_y[9:0]) < SCREEN_HEIGHT);

   // One shared multiplier forms the linear pixel index or the read byte index.
   assign start_col = (half_ff ? 11'(START_BYTE) : 11'd0) + 11'(read_col_ff);
   assign mul_a     = is_read ? 10'(read_row_ff) : pix_y[9:0];
   assign mul_b     = is_read ? MW'(ROW_BYTES) : MW'(SCREEN_WIDTH);
   assign add_term  = is_read ? start_col : pix_x[10:0];
   assign product   = 22'(mul_a) * 22'(mul_b);
   assign lin       = LW'(product) + LW'(add_term);

   assign bit_mask    = 8'(1) << bit_ff;
   assign mem_rd_en   = (state_ff == ST_READ);
   assign mem_wr_en   = (state_ff == ST_MODIFY) && !is_read;
   assign mem_wr_data = white_ff ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      white_in     = white_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            bit_in   = ~pix_x[2:0];
            white_in = (kind_ff == KIND_BLIT) ? (colour_sum >= light_threshold_ff) : !ink_ff;
            if (is_read) begin
               addr_in  = lin[AW-1:0];
               rd_ok_in = (32'(read_row_ff) < SCREEN_HEIGHT) &&
                          (32'(read_col_ff) < HALF_ROW_BYTES) &&
                          (32'(start_col) < ROW_BYTES);
               state_in = ST_READ;
            end else begin
               addr_in  = lin[3 +: AW];
               rd_ok_in = 1'b0;
               if (kind_ff == KIND_RESTART) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == KIND_BLIT && cur_state.pad_left != '0) begin
                  state_in = ST_IDLE;
               end else if (on_screen) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (!is_read) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_ok_ff ? mem_rd_data : WHITE_BYTE;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      bit_ff      <= bit_in;
      white_ff    <= white_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_byte_ff <= rsp_byte_in;
      if (req_accept) begin
         kind_ff     <= req_chan.kind;
         pixel_ff    <= req_chan.pixel_bytes;
         plot_x_ff   <= req_chan.plot_x;
         plot_y_ff   <= req_chan.plot_y;
         ink_ff      <= req_chan.ink;
         half_ff     <= req_chan.half;
         read_row_ff <= req_chan.read_row;
         read_col_ff <= req_chan.read_column;
      end
   end

   assign req_chan.ready     = (state_ff == ST_IDLE) && !clear_busy;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_byte = rsp_byte_ff;

   mfb_cursor u_cursor (
      .clock (clock),
      .reset (reset),
      .cfg   (cur_cfg),
      .ctrl  (cur_ctrl),
      .state (cur_state)
   );

   mfb_frame_mem #(
      .DEPTH (FRAME_BYTES),
      .AW    (AW)
   ) u_frame_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_wr_en),
      .wr_addr    (addr_ff),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (addr_ff),
      .rd_data    (mem_rd_data),
      .clear_busy (clear_busy)
   );
endmodule

// ===== sv/mfb_checker.sv =====
// Port-level checks for the blit engine top level, attached by the bind below.
// Depends on mono_framebuffer_blit_engine_top and its channel interfaces.
module mfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte
);
   // The clearing pass holds the request side off straight after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request ready during the clearing pass");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // One word at a time: the cycle after an acceptance takes no new word.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in flight");

   // A response needs at least the memory read after its request.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response raised the cycle after a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_byte)))
      else $error("stalled response word changed");
endmodule

bind mono_framebuffer_blit_engine_top mfb_checker u_mfb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_byte (rsp_chan.read_byte)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the monochrome frame store blit engine: a directed table, then
// random phases under several register settings. Depends on mfb_pkg, mfb_req_if, mfb_rsp_if.
module tb_top;
   import mfb_pkg::*;

   localparam int SCREEN_W      = SCREEN_WIDTH_DEF;
   localparam int SCREEN_H      = SCREEN_HEIGHT_DEF;
   localparam int HALF_BYTES    = HALF_ROW_BYTES_DEF;
   localparam int ROW_BYTES     = SCREEN_W / 8;
   localparam int FRAME_BYTES   = (SCREEN_W * SCREEN_H + 7) / 8;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_WORDS   = 210;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4 * FRAME_BYTES;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        pixel_bytes;
      logic signed [10:0] plot_x;
      logic signed [9:0]  plot_y;
      logic               ink;
      logic               half;
      logic [8:0]         read_row;
      logic [5:0]         read_column;
   } fb_word_type;

   typedef struct packed {
      fb_word_type word;
      logic        typed;
      logic [7:0]  typed_byte;
   } fb_row_type;

   // Rows marked typed carry the byte that must come back; the rest follow the predictor.
   localparam fb_row_type OPENING_ROWS [25] = '{
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b1, 8'hFF},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b1, 9'd271, 6'd49}, 1'b1, 8'hFF},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd511, 6'd0},  1'b1, 8'hFF},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b1, 9'd0,   6'd63}, 1'b1, 8'hFF},
      '{'{KIND_PLOT,    16'h0000, 11'sd0,    10'sd0,    1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b1, 8'h7F},
      '{'{KIND_PLOT,    16'h0000, 11'sd791,  10'sd271,  1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b1, 9'd271, 6'd49}, 1'b1, 8'hFE},
      '{'{KIND_PLOT,    16'h0000, -11'sd1,   10'sd0,    1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_PLOT,    16'h0000, 11'sd792,  10'sd0,    1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_PLOT,    16'h0000, 11'h400,   10'h200,   1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_PLOT,    16'h0000, 11'sd1023, 10'sd511,  1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_PLOT,    16'h0000, 11'sd7,    10'sd0,    1'b1, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b1, 8'h7E},
      '{'{KIND_PLOT,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b1, 8'hFE},
      '{'{KIND_BLIT,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_BLIT,    16'hFFFF, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_BLIT,    16'h00F8, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_RESTART, 16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_BLIT,    16'hFFFF, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd0},  1'b0, 8'h00},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b1, 9'd0,   6'd0},  1'b1, 8'hFF},
      '{'{KIND_READ,    16'h0000, 11'sd0,    10'sd0,    1'b0, 1'b0, 9'd0,   6'd49}, 1'b1, 8'hFF}
   };

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   mfb_req_if req_bus ();
   mfb_rsp_if rsp_bus ();

   mono_framebuffer_blit_engine_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   // Predicted frame, blit cursor and register copies.
   logic [7:0]         shadow_frame [FRAME_BYTES];
   logic [9:0]         cur_column;
   logic [8:0]         cur_row;
   logic [9:0]         pad_count;
   logic signed [10:0] cfg_x0;
   logic signed [9:0]  cfg_y0;
   logic [9:0]         cfg_width;
   logic [8:0]         cfg_height;
   logic [9:0]         cfg_pad;
   logic               cfg_big;
   logic [9:0]         cfg_threshold;

   logic [7:0] scanout_bytes_due [$];
   logic [7:0] due_byte;
   int         fault_count = 0;
   int         stalled_cycles = 0;
   int         send_idle_pct = 16;
   int         recv_idle_pct = 45;
   bit         hold_pending = 1'b0;

   function automatic void paint_pixel(input int x, input int y, input bit white);
      int pos;
      if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
      pos = (y * SCREEN_W + x) / 8;
      if (pos >= FRAME_BYTES) return;
      shadow_frame[pos][7 - (x % 8)] = white;
   endfunction

   function automatic void blit_step(input logic [15:0] raw);
      logic [15:0] pix;
      int          sum;
      int          w;
      int          h;
      w = (cfg_width == 0) ? 1 : int'(cfg_width);
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      if (pad_count != 0) begin
         pad_count = pad_count - 1'b1;
         return;
      end
      pix = cfg_big ? raw : {raw[7:0], raw[15:8]};
      sum = int'(pix[15:11]) * 8 + int'(pix[10:5]) * 4 + int'(pix[4:0]) * 8;
      paint_pixel(int'(cfg_x0) + int'(cur_column), int'(cfg_y0) + int'(cur_row),
                  sum >= int'(cfg_threshold));
      cur_column = cur_column + 1'b1;
      // The column counter is ten bits wide, so a wrap to zero also ends the row.
      if (int'(cur_column) >= w || cur_column == 0) begin
         cur_column = '0;
         cur_row    = cur_row + 1'b1;
         pad_count  = cfg_pad;
         if (int'(cur_row) >= h || cur_row == 0) begin
            cur_row   = '0;
            pad_count = '0;
         end
      end
   endfunction

   function automatic logic [7:0] fetch_byte(input logic half, input logic [8:0] row,
                                             input logic [5:0] column);
      int start;
      int idx;
      start = (half && ROW_BYTES > HALF_BYTES) ? ROW_BYTES - HALF_BYTES : 0;
      if (int'(row) >= SCREEN_H || int'(column) >= HALF_BYTES) return WHITE_BYTE;
      if (start + int'(column) >= ROW_BYTES) return WHITE_BYTE;
      idx = int'(row) * ROW_BYTES + start + int'(column);
      if (idx >= FRAME_BYTES) return WHITE_BYTE;
      return shadow_frame[idx];
   endfunction

   function automatic void advance_frame(input fb_word_type w, output bit makes_byte,
                                         output logic [7:0] frame_byte);
      makes_byte = 1'b0;
      frame_byte = WHITE_BYTE;
      case (w.kind)
         KIND_BLIT: blit_step(w.pixel_bytes);
         KIND_PLOT: paint_pixel(int'(w.plot_x), int'(w.plot_y), !w.ink);
         KIND_READ: begin
            makes_byte = 1'b1;
            frame_byte = fetch_byte(w.half, w.read_row, w.read_column);
         end
         default: begin
            cur_column = '0;
            cur_row    = '0;
            pad_count  = '0;
         end
      endcase
   endfunction

   // Most plots and reads are aimed at or near the current rectangle so that blitted pixels are seen.
   function automatic fb_word_type random_word();
      fb_word_type w;
      int          pick;
      int          span;
      int          xp;
      int          yp;
      int          col_byte;
      w.pixel_bytes = 16'($urandom);
      w.plot_x      = 11'($urandom);
      w.plot_y      = 10'($urandom);
      w.ink         = 1'($urandom);
      w.half        = 1'($urandom);
      w.read_row    = 9'($urandom);
      w.read_column = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 60) begin
         w.kind = KIND_BLIT;
      end else if (pick < 72) begin
         w.kind = KIND_PLOT;
         if ($urandom_range(99) < 70) begin
            w.plot_x = 11'(int'(cfg_x0) + int'($urandom_range(44)) - 4);
            w.plot_y = 10'(int'(cfg_y0) + int'($urandom_range(14)) - 2);
         end
      end else if (pick < 97) begin
         w.kind = KIND_READ;
         if ($urandom_range(99) < 70) begin
            span = (cfg_width == 0) ? 1 : ((cfg_width > 64) ? 64 : int'(cfg_width));
            xp   = int'(cfg_x0) + int'($urandom_range(span - 1));
            if (xp < 0 || xp >= SCREEN_W) xp = $urandom_range(SCREEN_W - 1);
            span = (cfg_height == 0) ? 1 : ((cfg_height > 12) ? 12 : int'(cfg_height));
            yp   = int'(cfg_y0) + int'($urandom_range(span - 1));
            if (yp < 0 || yp >= SCREEN_H) yp = $urandom_range(SCREEN_H - 1);
            col_byte   = xp / 8;
            w.read_row = 9'(yp);
            if (col_byte >= HALF_BYTES ||
                (col_byte == ROW_BYTES - HALF_BYTES && $urandom_range(1) == 1)) begin
               w.half        = 1'b1;
               w.read_column = 6'(col_byte - (ROW_BYTES - HALF_BYTES));
            end else begin
               w.half        = 1'b0;
               w.read_column = 6'(col_byte);
            end
         end
      end else begin
         w.kind = KIND_RESTART;
      end
      return w;
   endfunction

   task automatic send_word(input fb_word_type w, input logic typed,
                            input logic [7:0] typed_byte);
      bit         makes_byte;
      logic [7:0] frame_byte;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= w.kind;
      req_bus.pixel_bytes <= w.pixel_bytes;
      req_bus.plot_x      <= w.plot_x;
      req_bus.plot_y      <= w.plot_y;
      req_bus.ink         <= w.ink;
      req_bus.half        <= w.half;
      req_bus.read_row    <= w.read_row;
      req_bus.read_column <= w.read_column;
      do @(posedge clock); while (!req_bus.ready);
      advance_frame(w, makes_byte, frame_byte);
      if (makes_byte) scanout_bytes_due.push_back(typed ? typed_byte : frame_byte);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic pick_int(output int v, input int lo, input int hi, input int rare_lo,
                           input int rare_hi);
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) v = rare_lo;
      else if (roll < 14) v = rare_hi;
      else v = lo + int'($urandom_range(hi - lo));
   endtask

   // The first phases use fixed settings that reach the extremes and the special cases.
   task automatic load_settings(input int phase);
      int v;
      case (phase)
         0: begin
            cfg_x0 = -11'sd3;   cfg_y0 = -10'sd1; cfg_width = 10'd5; cfg_height = 9'd3;
            cfg_pad = 10'd2;    cfg_big = 1'b1;   cfg_threshold = 10'd400;
         end
         1: begin
            cfg_x0 = 11'sd1023; cfg_y0 = 10'sd511; cfg_width = 10'd0; cfg_height = 9'd0;
            cfg_pad = 10'd1023; cfg_big = 1'b0;    cfg_threshold = 10'd1023;
         end
         2: begin
            cfg_x0 = 11'h400;   cfg_y0 = 10'h200; cfg_width = 10'd1023; cfg_height = 9'd511;
            cfg_pad = 10'd0;    cfg_big = 1'b1;   cfg_threshold = 10'd0;
         end
         default: begin
            pick_int(v, -40, 800, -1024, 1023);  cfg_x0 = 11'(v);
            pick_int(v, -10, 271, -512, 511);    cfg_y0 = 10'(v);
            pick_int(v, 1, 40, 0, 1023);         cfg_width = 10'(v);
            pick_int(v, 1, 12, 0, 511);          cfg_height = 9'(v);
            pick_int(v, 0, 6, 1023, 0);          cfg_pad = 10'(v);
            cfg_big = 1'($urandom);
            pick_int(v, 200, 600, 0, 765 + int'($urandom_range(258)));
            cfg_threshold = 10'(v);
         end
      endcase
      write_reg(CSR_RECT_X_START,    11'(cfg_x0));
      write_reg(CSR_RECT_Y_START,    11'(cfg_y0));
      write_reg(CSR_RECT_WIDTH,      11'(cfg_width));
      write_reg(CSR_RECT_HEIGHT,     11'(cfg_height));
      write_reg(CSR_ROW_PAD,         11'(cfg_pad));
      write_reg(CSR_BYTE_ORDER_BIG,  11'(cfg_big));
      write_reg(CSR_LIGHT_THRESHOLD, 11'(cfg_threshold));
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (scanout_bytes_due.size() != 0) @(negedge clock);
      // Blits and plots leave no word behind, so give the last one time to finish.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_bus.ready <= 1'b0;
            hold_pending = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (scanout_bytes_due.size() == 0) begin
            if (fault_count < 10) $display("unexpected read word %02h", rsp_bus.read_byte);
            fault_count++;
         end else begin
            due_byte = scanout_bytes_due.pop_front();
            if (rsp_bus.read_byte !== due_byte) begin
               if (fault_count < 10)
                  $display("read_byte mismatch: expected %02h, got %02h",
                           due_byte, rsp_bus.read_byte);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_BLIT;
      req_bus.pixel_bytes = '0;
      req_bus.plot_x      = '0;
      req_bus.plot_y      = '0;
      req_bus.ink         = 1'b0;
      req_bus.half        = 1'b0;
      req_bus.read_row    = '0;
      req_bus.read_column = '0;
      for (int i = 0; i < FRAME_BYTES; i++) shadow_frame[i] = WHITE_BYTE;
      cur_column    = '0;
      cur_row       = '0;
      pad_count     = '0;
      cfg_x0        = '0;
      cfg_y0        = '0;
      cfg_width     = RECT_WIDTH_RESET;
      cfg_height    = RECT_HEIGHT_RESET;
      cfg_pad       = '0;
      cfg_big       = 1'b0;
      cfg_threshold = LIGHT_THRESHOLD_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (OPENING_ROWS[i])
         send_word(OPENING_ROWS[i].word, OPENING_ROWS[i].typed, OPENING_ROWS[i].typed_byte);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_block();
         if (phase == 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 16;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_settings(phase);
         // One long stall of the scan-out side so that pending reads back up into the input.
         if (phase == 4) hold_pending = 1'b1;
         repeat (PHASE_WORDS) send_word(random_word(), 1'b0, 8'h00);
      end

      req_bus.valid <= 1'b0;
      while (scanout_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && scanout_bytes_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
